/* hdl/stream_pattern_masker_top_assert.svh */
// assertion macros shared by the rtl
`ifndef STREAM_PATTERN_MASKER_TOP_ASSERT_SVH
`define STREAM_PATTERN_MASKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spm: assertion failed");
`define SPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spm: assertion failed");
`else
`define SPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/spm_pkg.sv */
`default_nettype none
package spm_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 5;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned REG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  pattern_len;
        logic [WORD_W-1:0] pattern_low;
        logic [WORD_W-1:0] pattern_high;
    } t_cfg;

    typedef struct packed {
        logic shift;
        logic ins;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* hdl/spm_if.sv */
`default_nettype none
interface spm_in_if;
    logic                        valid;
    logic                        ready;
    logic [spm_pkg::BYTE_W-1:0]  in_byte;
    logic                        in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface spm_out_if;
    logic                        valid;
    logic                        ready;
    logic [spm_pkg::BYTE_W-1:0]  out_byte;
    logic                        out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

/* hdl/spm_apb.sv */
`default_nettype none
module spm_apb (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [spm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [spm_pkg::WORD_W-1:0]  pwdata,
    output logic      [spm_pkg::WORD_W-1:0]  prdata,
    output logic                             pready,
    output spm_pkg::t_cfg                    o_cfg
);

    spm_pkg::t_cfg                    r_cfg;
    logic [spm_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                             wr_en;

    assign reg_idx = paddr[spm_pkg::ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                spm_pkg::REG_PATTERN_LEN:  r_cfg.pattern_len  <= pwdata[spm_pkg::LEN_W-1:0];
                spm_pkg::REG_PATTERN_LOW:  r_cfg.pattern_low  <= pwdata;
                spm_pkg::REG_PATTERN_HIGH: r_cfg.pattern_high <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            spm_pkg::REG_PATTERN_LEN:
                prdata = {{(spm_pkg::WORD_W-spm_pkg::LEN_W){1'b0}}, r_cfg.pattern_len};
            spm_pkg::REG_PATTERN_LOW:  prdata = r_cfg.pattern_low;
            spm_pkg::REG_PATTERN_HIGH: prdata = r_cfg.pattern_high;
            default:                   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/spm_cell.sv */
`default_nettype none
module spm_cell (
    input  wire logic                        i_clk,
    input  wire spm_pkg::t_cell_ctl          i_ctl,
    input  wire logic [spm_pkg::BYTE_W-1:0]  i_in_byte,
    input  wire logic [spm_pkg::BYTE_W-1:0]  i_next_byte,
    input  wire logic [spm_pkg::BYTE_W-1:0]  i_pat_byte,
    input  wire logic                        i_cmp_en,
    output logic      [spm_pkg::BYTE_W-1:0]  o_byte,
    output logic                             o_match
);

    logic [spm_pkg::BYTE_W-1:0] r_byte;
    logic [spm_pkg::BYTE_W-1:0] n_byte;

    // the incoming item lands here when this is the first free slot
    assign o_byte  = i_ctl.ins ? i_in_byte : r_byte;
    assign o_match = !i_cmp_en || (o_byte == i_pat_byte);
    assign n_byte  = i_ctl.shift ? i_next_byte : o_byte;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule
`default_nettype wire

/* hdl/stream_pattern_masker_top.sv */
// channel  dir  handshake      payload
// i_in     in   valid/ready    in_byte[7:0], in_last
// o_out    out  valid/ready    out_byte[7:0], out_last
// apb      in   psel/penable   paddr[4:0], pwdata[63:0], prdata[63:0]
//
// one item per cycle unless o_out stalls or a flush holds ready low: an item that fills the window
// is taken and the oldest byte leaves in the same cycle, through a chain of PATTERN_MAX byte cells
// the last item of a stream flushes the window, one output per cycle while o_out is not stalled,
// with i_in.ready low until the flush is done
// a stall on o_out lets the window fill up, then ready drops until the output moves
// i_rst_n is synchronous; it clears fill, star count, flags and the output valid
`default_nettype none
`include "stream_pattern_masker_top_assert.svh"
module stream_pattern_masker_top #(
    parameter int unsigned PATTERN_MAX = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    spm_in_if.sink                           i_in,
    spm_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [spm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [spm_pkg::WORD_W-1:0]  pwdata,
    output logic      [spm_pkg::WORD_W-1:0]  prdata,
    output logic                             pready
);

    localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PATTERN_MAX);
    localparam logic [spm_pkg::LEN_W-1:0] LEN_MAX = spm_pkg::LEN_W'(PATTERN_MAX);

    spm_pkg::t_cfg                       cfg;
    logic [spm_pkg::LEN_W-1:0]           eff_len;

    logic [FILL_W-1:0]                   r_fill, n_fill;
    logic [FILL_W-1:0]                   r_star, n_star;
    logic                                r_drain, n_drain;
    logic                                r_flush, n_flush;
    logic                                r_ov;
    logic [spm_pkg::BYTE_W-1:0]          r_ob;
    logic                                r_ol;

    logic                                insert;
    logic                                active;
    logic                                flush_act;
    logic                                can_out;
    logic                                pop;
    logic                                match;
    logic                                flush_done;
    logic [FILL_W-1:0]                   v_fill;
    logic [FILL_W-1:0]                   after;
    logic [spm_pkg::LEN_W-1:0]           v_fill_l;
    logic [spm_pkg::LEN_W-1:0]           after_l;
    logic [2*spm_pkg::WORD_W-1:0]        pat_bits;
    logic [PATTERN_MAX-1:0]              match_bits;
    logic [spm_pkg::BYTE_W-1:0]          cell_v [PATTERN_MAX+1];
    logic [spm_pkg::BYTE_W-1:0]          head_byte;

    spm_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign eff_len  = (cfg.pattern_len > LEN_MAX) ? LEN_MAX : cfg.pattern_len;
    assign pat_bits = {cfg.pattern_high, cfg.pattern_low};

    assign i_in.ready = !r_drain;
    assign insert     = i_in.valid && !r_drain;
    assign active     = insert || r_drain;
    assign flush_act  = r_flush || (insert && i_in.in_last);
    assign can_out    = !r_ov || o_out.ready;

    assign v_fill   = r_fill + FILL_W'(insert);
    assign v_fill_l = spm_pkg::LEN_W'(v_fill);
    assign pop      = can_out && active && (v_fill != '0)
                      && (flush_act || v_fill_l >= eff_len);
    assign after    = v_fill - FILL_W'(pop);
    assign after_l  = spm_pkg::LEN_W'(after);

    assign cell_v[PATTERN_MAX] = '0;

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        spm_pkg::t_cell_ctl ctl;
        assign ctl = '{shift: pop, ins: insert && (r_fill == FILL_W'(i))};

        spm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_in_byte   (i_in.in_byte),
            .i_next_byte (cell_v[i+1]),
            .i_pat_byte  (pat_bits[spm_pkg::BYTE_W*i +: spm_pkg::BYTE_W]),
            .i_cmp_en    (spm_pkg::LEN_W'(i) < eff_len),
            .o_byte      (cell_v[i]),
            .o_match     (match_bits[i])
        );
    end

    assign head_byte  = cell_v[0];
    assign match      = (eff_len != '0) && (v_fill_l >= eff_len) && (&match_bits);
    assign flush_done = pop && flush_act && (after == '0);

    always_comb begin
        n_fill  = after;
        n_drain = active && (after != '0) && (flush_act || after_l >= eff_len);
        n_flush = n_drain && flush_act;
        n_star  = r_star;
        if (pop) begin
            if (r_star != '0) begin
                n_star = r_star - FILL_W'(1);
            end else if (match) begin
                n_star = FILL_W'(eff_len - spm_pkg::LEN_W'(1));
            end
        end
        if (flush_done) begin
            n_star = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_star  <= '0;
            r_drain <= 1'b0;
            r_flush <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_star  <= n_star;
            r_drain <= n_drain;
            r_flush <= n_flush;
            if (pop) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ob <= ((r_star != '0) || match) ? spm_pkg::STAR_BYTE : head_byte;
            r_ol <= flush_done;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.out_last = r_ol;

    `SPM_ASSERT_NOW(a_flush_in_drain, i_clk, i_rst_n, r_flush, r_drain)
    `SPM_ASSERT_NOW(a_insert_in_range, i_clk, i_rst_n, insert, r_fill < FILL_MAX)
    `SPM_ASSERT_NOW(a_star_in_range, i_clk, i_rst_n, r_star != '0, r_star < FILL_MAX)
    `SPM_ASSERT_NEXT(a_flush_rearms, i_clk, i_rst_n, flush_done,
                     (r_fill == '0) && (r_star == '0) && !r_flush && !r_drain)

endmodule
`default_nettype wire

/* tb/sv/stream_pattern_masker_checker.sv */
`default_nettype none
module stream_pattern_masker_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    spm_in_if                               i_in,
    spm_out_if                              i_out,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic                       i_pready,
    input  wire logic [spm_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [spm_pkg::WORD_W-1:0] i_pwdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_result_count,
    output int                              o_star_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WIN_DEPTH    = 16;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [spm_pkg::BYTE_W-1:0] data;
        logic                       last;
    } t_masked_byte;

    t_masked_byte               expected_bytes[$];
    logic [spm_pkg::LEN_W-1:0]  len_reg;
    logic [spm_pkg::WORD_W-1:0] pat_lo;
    logic [spm_pkg::WORD_W-1:0] pat_hi;
    logic [spm_pkg::BYTE_W-1:0] window [WIN_DEPTH];
    int unsigned                fill;
    int unsigned                stars;
    int                         fails;
    int                         results;
    int                         star_bytes;

    // oldest len window bytes against the pattern
    function automatic logic window_hit(int unsigned len);
        logic [spm_pkg::BYTE_W-1:0] want;
        if (len == 0 || fill < len) return 1'b0;
        for (int i = 0; i < len; i++) begin
            want = (i < 8) ? pat_lo[8*(i%8) +: 8] : pat_hi[8*(i%8) +: 8];
            if (window[i] != want) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [spm_pkg::BYTE_W-1:0] pop_oldest(int unsigned len);
        logic [spm_pkg::BYTE_W-1:0] b;
        b = window[0];
        if (stars > 0) begin
            b = spm_pkg::STAR_BYTE;
            stars--;
        end else if (window_hit(len)) begin
            stars = len - 1;
            b = spm_pkg::STAR_BYTE;
        end
        for (int i = 0; i < WIN_DEPTH - 1; i++) window[i] = window[i+1];
        window[WIN_DEPTH-1] = '0;
        fill--;
        return b;
    endfunction

    function automatic void predict_masking(logic [spm_pkg::BYTE_W-1:0] b, logic last);
        int unsigned  len;
        int           n;
        t_masked_byte r;
        // lengths above the window saturate
        len = (len_reg > WIN_DEPTH) ? WIN_DEPTH : int'(len_reg);
        if (fill >= WIN_DEPTH) void'(pop_oldest(len));
        window[fill] = b;
        fill++;
        n = 0;
        while (fill > 0 && (last || fill >= len) && n < WIN_DEPTH) begin
            r.data = pop_oldest(len);
            r.last = last && (fill == 0);
            expected_bytes.push_back(r);
            n++;
        end
        if (last) begin
            fill  = 0;
            stars = 0;
            foreach (window[i]) window[i] = '0;
        end
    endfunction

    function automatic void compare_out_byte(logic [spm_pkg::BYTE_W-1:0] b, logic last);
        t_masked_byte want;
        results++;
        if (b == spm_pkg::STAR_BYTE) star_bytes++;
        if (expected_bytes.size() == 0) begin
            if (fails < REPORT_LIMIT)
                $display("out item %0d: byte %02h last %0b arrived with nothing expected",
                         results, b, last);
            fails++;
            return;
        end
        want = expected_bytes.pop_front();
        if (want.data !== b || want.last !== last) begin
            if (fails < REPORT_LIMIT)
                $display("out item %0d: expected byte %02h last %0b, got byte %02h last %0b",
                         results, want.data, want.last, b, last);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_reg = '0;
            pat_lo  = '0;
            pat_hi  = '0;
            fill    = 0;
            stars   = 0;
            foreach (window[i]) window[i] = '0;
            expected_bytes.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[spm_pkg::ADDR_W-1:3])
                    spm_pkg::REG_PATTERN_LEN:  len_reg = i_pwdata[spm_pkg::LEN_W-1:0];
                    spm_pkg::REG_PATTERN_LOW:  pat_lo  = i_pwdata;
                    spm_pkg::REG_PATTERN_HIGH: pat_hi  = i_pwdata;
                    default: ;
                endcase
            end
            // input first: predictions are queued before this edge's output is compared
            if (i_in.valid && i_in.ready) predict_masking(i_in.in_byte, i_in.in_last);
            if (i_out.valid && i_out.ready) compare_out_byte(i_out.out_byte, i_out.out_last);
        end
        o_pending      <= expected_bytes.size();
        o_fail_count   <= fails;
        o_result_count <= results;
        o_star_count   <= star_bytes;
    end

endmodule
`default_nettype wire

/* tb/sv/stream_pattern_masker_top_tb.sv */
`default_nettype none
module stream_pattern_masker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD    = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned LONG_STALL    = 120;
    localparam int unsigned PHASES        = 9;
    localparam int unsigned PHASE_ITEMS   = 47;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [spm_pkg::ADDR_W-1:0] paddr;
    logic [spm_pkg::WORD_W-1:0] pwdata;
    logic [spm_pkg::WORD_W-1:0] prdata;
    logic                       pready;

    spm_in_if  in_ch();
    spm_out_if out_ch();

    int                         fail_count;
    int                         pending_results;
    int                         result_count;
    int                         star_count;

    int unsigned                tx_idle_pct;
    int unsigned                rx_idle_pct;
    int unsigned                stall_asked;
    logic [spm_pkg::BYTE_W-1:0] cur_pat [16];
    int unsigned                cur_eff;
    int unsigned                stream_left;
    int unsigned                items_sent;
    int unsigned                streams_sent;
    int unsigned                settings_used;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    stream_pattern_masker_top #(
        .PATTERN_MAX(16)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    stream_pattern_masker_checker mask_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results),
        .o_result_count(result_count),
        .o_star_count  (star_count)
    );

    task automatic send_byte(input logic [spm_pkg::BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (last) streams_sent++;
    endtask

    task automatic stream_byte(input logic [spm_pkg::BYTE_W-1:0] b);
        logic last;
        stream_left--;
        last = (stream_left == 0);
        if (last) stream_left = $urandom_range(1, 40);
        send_byte(b, last);
    endtask

    task automatic write_reg(input logic [spm_pkg::REG_IDX_W-1:0] idx,
                             input logic [spm_pkg::WORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender quiet until every expected byte is out and the window has settled
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [spm_pkg::LEN_W-1:0] len,
                                 input logic [spm_pkg::WORD_W-1:0] lo,
                                 input logic [spm_pkg::WORD_W-1:0] hi);
        logic [spm_pkg::WORD_W-1:0] noise;
        noise = {$urandom, $urandom};
        wait_drained();
        // only the low bits of the length word count
        write_reg(spm_pkg::REG_PATTERN_LEN, (noise & ~64'h1F) | 64'(len));
        write_reg(spm_pkg::REG_PATTERN_LOW, lo);
        write_reg(spm_pkg::REG_PATTERN_HIGH, hi);
        cur_eff = (len > 16) ? 16 : len;
        for (int i = 0; i < 8; i++) begin
            cur_pat[i]     = lo[8*i +: 8];
            cur_pat[i + 8] = hi[8*i +: 8];
        end
        settings_used++;
    endtask

    initial begin : rx_side
        int unsigned stall_served;
        int unsigned stall_left;
        stall_served = 0;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_served != stall_asked) begin
                stall_served++;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timed out after %0d cycles, %0d bytes still expected",
                         cycles, pending_results);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [spm_pkg::LEN_W-1:0]  phase_lens [PHASES];
        logic [spm_pkg::BYTE_W-1:0] pat_bytes [16];
        logic [spm_pkg::WORD_W-1:0] lo;
        logic [spm_pkg::WORD_W-1:0] hi;
        int unsigned                sent;
        int unsigned                k;
        int unsigned                r;

        phase_lens    = '{5'd2, 5'd16, 5'd0, 5'd3, 5'd31, 5'd1, 5'd20, 5'd5, 5'd8};
        tx_idle_pct   = 11;
        rx_idle_pct   = 69;
        stall_asked   = 0;
        cur_eff       = 0;
        items_sent    = 0;
        streams_sent  = 0;
        settings_used = 0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        in_ch.in_last <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through straight out of reset, zero byte included
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // self-overlapping pattern, then a match that completes in the flush
        apply_setting(5'd2, 64'h6161, 64'h0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b1);
        send_byte("b", 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b1);

        // stars already loaded keep running after the length drops to zero
        apply_setting(5'd4, 64'h64636261, {$urandom, $urandom});
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("c", 1'b0);
        send_byte("d", 1'b0);
        wait_drained();
        write_reg(spm_pkg::REG_PATTERN_LEN, 64'd0);
        send_byte("e", 1'b1);

        // shorter length mid-stream pushes the held bytes out together
        apply_setting(5'd3, 64'h7a7978, 64'h0);
        send_byte("x", 1'b0);
        send_byte("y", 1'b0);
        wait_drained();
        write_reg(spm_pkg::REG_PATTERN_LEN, 64'd1);
        send_byte("q", 1'b1);

        stream_left = $urandom_range(1, 40);
        for (int p = 0; p < PHASES; p++) begin
            tx_idle_pct = (p < 3) ? 11 : (p < 6) ? 69 : 0;
            rx_idle_pct = (p < 3) ? 69 : (p < 6) ? 11 : 0;
            // odd phases draw from two letters so the pattern overlaps itself
            for (int i = 0; i < 16; i++)
                pat_bytes[i] = p[0] ? 8'($urandom_range(8'h61, 8'h62)) : 8'($urandom_range(255));
            for (int i = 0; i < 8; i++) begin
                lo[8*i +: 8] = pat_bytes[i];
                hi[8*i +: 8] = pat_bytes[i + 8];
            end
            // streams may run on across the setting change
            apply_setting(phase_lens[p], lo, hi);
            if (p == 6) stall_asked++;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (cur_eff > 0 && r < 45) begin
                    // whole pattern mostly, sometimes only a prefix
                    k = ($urandom_range(3) == 0) ? $urandom_range(1, cur_eff) : cur_eff;
                    for (int i = 0; i < k; i++) stream_byte(cur_pat[i]);
                    sent += k;
                end else if (r < 80) begin
                    stream_byte(cur_pat[$urandom_range(15)]);
                    sent++;
                end else begin
                    stream_byte(8'($urandom_range(255)));
                    sent++;
                end
            end
        end
        send_byte(8'($urandom_range(255)), 1'b1);
        wait_drained();

        $display("covered %0d items in %0d streams under %0d pattern settings, lengths 0 to 31",
                 items_sent, streams_sent, settings_used);
        $display("%0d output bytes checked, %0d of them stars, %0d mismatches, %0d missing",
                 result_count, star_count, fail_count, pending_results);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
